[rtl/bes_pkg.sv]
// ----------------------------------------------------------------------------
// bes_pkg: shared types and constants for the 3x3 binary erosion stream
// Payload structs, the item passed from front to back, register indexes.
// ----------------------------------------------------------------------------
package bes_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int OCOL_W     = 10;
  localparam int ICOL_W     = 12;   // widest column index any line store depth needs
  localparam int THR_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ROWS_MAX   = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic [ROW_W-1:0]  out_row;
    logic [OCOL_W-1:0] out_col;
    logic              run_last;
    logic              frame_done;
  } out_t;

  // which results an item produces, decided at the front
  typedef struct packed {
    logic emit_ctr;   // window centre, one row up and one column left
    logic ero_ok;     // centre is not in the left border column
    logic emit_edge;  // right border pixel of the row above
    logic emit_self;  // the input pixel itself (top or bottom row)
    logic done;       // last pixel of the frame
  } flags_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  up;
    logic [PIX_W-1:0]  mid;
    logic [ROW_W-1:0]  row;
    logic [ICOL_W-1:0] col;
    flags_t            flg;
  } item_t;

endpackage

[rtl/bes_ram.sv]
// ----------------------------------------------------------------------------
// bes_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/bes_front.sv]
// ----------------------------------------------------------------------------
// bes_front: position tracking, classification and line stores
// Tracks row and column, reads the two line stores, tags each item.
// ----------------------------------------------------------------------------
module bes_front #(
  parameter int MAX_COLS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  bes_pkg::in_t                in_data,
  output logic                        in_stall,
  input  logic [bes_pkg::ROW_W-1:0]   last_row,
  input  logic [$clog2(MAX_COLS)-1:0] last_col,
  output logic                        q_push,
  output bes_pkg::item_t              q_data,
  input  logic                        q_full
);
  import bes_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   r0, r_cur;
  logic [ROW_W:0]     r1;
  logic [CW-1:0]      c0, c_cur;
  logic               wrap_c, at_last_col, at_last_row;
  flags_t             flg;
  logic               in_acc, s1_move;

  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [CW-1:0]      s1_col_r;
  flags_t             s1_flg_r;
  logic               byp_r;
  logic [2*PIX_W-1:0] byp_data_r;
  logic [2*PIX_W-1:0] ram_rdata, line;

  assign in_stall = s1_valid_r && q_full;
  assign s1_move  = s1_valid_r && !q_full;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    r0          = in_data.frame_start ? '0 : row_r;
    c0          = in_data.frame_start ? '0 : col_r;
    wrap_c      = c0 > last_col;
    c_cur       = wrap_c ? '0 : c0;
    r1          = wrap_c ? {1'b0, r0} + (ROW_W+1)'(1) : {1'b0, r0};
    r_cur       = (r1 > {1'b0, last_row}) ? '0 : r1[ROW_W-1:0];
    at_last_col = c_cur == last_col;
    at_last_row = r_cur == last_row;

    flg.emit_ctr  = (r_cur > ROW_W'(1)) && (c_cur != '0);
    flg.ero_ok    = c_cur > CW'(1);
    flg.emit_edge = (r_cur > ROW_W'(1)) && at_last_col;
    flg.emit_self = (r_cur == '0) || at_last_row;
    flg.done      = at_last_row && at_last_col;

    if (at_last_col) begin
      col_nxt = '0;
      row_nxt = at_last_row ? '0 : r_cur + ROW_W'(1);
    end else begin
      col_nxt = c_cur + CW'(1);
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        // the line entry being read is written back this same edge
        byp_r <= s1_move && (c_cur == s1_col_r);
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_data.pixel_in;
      s1_row_r   <= r_cur;
      s1_col_r   <= c_cur;
      s1_flg_r   <= flg;
      byp_data_r <= {line[PIX_W-1:0], s1_pix_r};
    end
  end

  // one entry holds {row r-2, row r-1}; written back as {row r-1, row r}
  bes_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata ({line[PIX_W-1:0], s1_pix_r}),
    .re    (in_acc),
    .raddr (c_cur),
    .rdata (ram_rdata)
  );

  assign line = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    q_data.pix = s1_pix_r;
    q_data.up  = line[2*PIX_W-1:PIX_W];
    q_data.mid = line[PIX_W-1:0];
    q_data.row = s1_row_r;
    q_data.col = ICOL_W'(s1_col_r);
    q_data.flg = s1_flg_r;
  end

  assign q_push = s1_move;

endmodule

[rtl/bes_queue.sv]
// ----------------------------------------------------------------------------
// bes_queue: two-entry item queue between front and back
// Flip-flop FIFO; full blocks the front, empty idles the back.
// ----------------------------------------------------------------------------
module bes_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bes_pkg::item_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bes_pkg::item_t head
);
  import bes_pkg::*;

  item_t       ent_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/bes_back.sv]
// ----------------------------------------------------------------------------
// bes_back: 3x3 window, erosion decision and result sequencing
// Pops items in order, builds up to three results; drains one a cycle if not stalled.
// ----------------------------------------------------------------------------
module bes_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  bes_pkg::item_t            q_head,
  output logic                      q_pop,
  input  logic [bes_pkg::PIX_W-1:0] target,
  input  logic [bes_pkg::THR_W-1:0] threshold,
  output logic                      out_valid,
  output bes_pkg::out_t             out_data,
  input  logic                      out_stall
);
  import bes_pkg::*;

  logic [PIX_W-1:0] win_up_r  [2];
  logic [PIX_W-1:0] win_mid_r [2];
  logic [PIX_W-1:0] left_r    [2];

  out_t             pend_r [3];
  out_t             new_res [3];
  logic [2:0]       mask_r, mask_nxt, new_mask, sel_oh, mask_after;
  logic [1:0]       sel;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;
  logic             out_free, emit;

  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] centre;
  logic [3:0]       zeros;
  logic             erode;
  logic [ROW_W-1:0] r_m1;
  logic [ICOL_W-1:0] c_m1;

  always_comb begin
    centre = win_mid_r[1];
    win[0] = win_up_r[0];
    win[1] = win_up_r[1];
    win[2] = q_head.up;
    win[3] = win_mid_r[0];
    win[4] = win_mid_r[1];
    win[5] = q_head.mid;
    win[6] = left_r[0];
    win[7] = left_r[1];
    win[8] = q_head.pix;
    zeros  = '0;
    for (int i = 0; i < 9; i++) begin
      zeros = zeros + 4'((win[i] == '0) ? 1 : 0);
    end
    erode = q_head.flg.ero_ok && (centre == target) && (zeros > threshold);
    r_m1  = q_head.row - ROW_W'(1);
    c_m1  = q_head.col - ICOL_W'(1);

    new_mask = {q_head.flg.emit_self, q_head.flg.emit_edge, q_head.flg.emit_ctr};

    new_res[0].pixel_out  = erode ? '0 : centre;
    new_res[0].out_row    = r_m1;
    new_res[0].out_col    = c_m1[OCOL_W-1:0];
    new_res[0].run_last   = !new_mask[1] && !new_mask[2];
    new_res[0].frame_done = 1'b0;

    new_res[1].pixel_out  = q_head.mid;
    new_res[1].out_row    = r_m1;
    new_res[1].out_col    = q_head.col[OCOL_W-1:0];
    new_res[1].run_last   = !new_mask[2];
    new_res[1].frame_done = 1'b0;

    new_res[2].pixel_out  = q_head.pix;
    new_res[2].out_row    = q_head.row;
    new_res[2].out_col    = q_head.col[OCOL_W-1:0];
    new_res[2].run_last   = 1'b1;
    new_res[2].frame_done = q_head.flg.done;
  end

  // drain pending results lowest slot first
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    emit     = out_free && (mask_r != '0);
    if (mask_r[0]) begin
      sel = 2'd0;
    end else if (mask_r[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    sel_oh        = 3'b001 << sel;
    mask_after    = emit ? (mask_r & ~sel_oh) : mask_r;
    q_pop         = q_not_empty && (mask_after == '0);
    mask_nxt      = q_pop ? new_mask : mask_after;
    out_valid_nxt = emit ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        win_up_r[i]  <= '0;
        win_mid_r[i] <= '0;
        left_r[i]    <= '0;
      end
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        win_up_r[0]  <= win_up_r[1];
        win_up_r[1]  <= q_head.up;
        win_mid_r[0] <= win_mid_r[1];
        win_mid_r[1] <= q_head.mid;
        left_r[0]    <= left_r[1];
        left_r[1]    <= q_head.pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        pend_r[i] <= new_res[i];
      end
    end
    if (emit) begin
      out_data_r <= pend_r[sel];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/binary_erode_3x3_stream.sv]
// ----------------------------------------------------------------------------
// binary_erode_3x3_stream: streaming 3x3 erosion with neighbor zero count
// Front tags pixels and reads line stores, back runs the window and results.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------
//   in      | in_valid/in_stall  | in_data  : pixel_in, frame_start
//   out     | out_valid/out_stall| out_data : pixel_out, row, col, marks
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (ready always high)
//
// One pixel per clock while each gives at most one result and out_stall is low;
// results drain one per clock, so right border pixels below row 1 and bottom row
// pixels past column 0 each add a result to drain, the last pixel of the frame two.
// Results pass the line store read, queue and pending slots to a registered output.
// Synchronous reset clears counters, window and config, not the line store.
// A stalled output backs up through the queue into in_stall.
// ----------------------------------------------------------------------------
module binary_erode_3x3_stream #(
  parameter int MAX_COLS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  bes_pkg::in_t                     in_data,
  output logic                             in_stall,
  output logic                             out_valid,
  output bes_pkg::out_t                    out_data,
  input  logic                             out_stall,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bes_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bes_pkg::*;

  localparam int CW       = $clog2(MAX_COLS);
  localparam int COLS_RST = (MAX_COLS < 512) ? MAX_COLS : 512;

  logic [PIX_W-1:0] target_r;
  logic [THR_W-1:0] threshold_r;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic [CW-1:0]    last_col_r, last_col_nxt;
  logic [31:0]      col_tmp;
  logic             cfg_wr;

  logic             q_push, q_full, q_pop, q_not_empty;
  item_t            q_in, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // keep sizes as last index, clamped to the legal frame range
  always_comb begin
    if (cfg_data < CFG_DATA_W'(3)) begin
      last_row_nxt = ROW_W'(2);
    end else if (cfg_data > CFG_DATA_W'(ROWS_MAX)) begin
      last_row_nxt = ROW_W'(ROWS_MAX - 1);
    end else begin
      last_row_nxt = ROW_W'(cfg_data - CFG_DATA_W'(1));
    end
    if (cfg_data[10:0] < 11'd3) begin
      col_tmp = 32'd2;
    end else if (32'(cfg_data[10:0]) > 32'(MAX_COLS)) begin
      col_tmp = 32'(MAX_COLS - 1);
    end else begin
      col_tmp = 32'(cfg_data[10:0]) - 32'd1;
    end
    last_col_nxt = col_tmp[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= 8'd255;
      threshold_r <= 4'd4;
      last_row_r  <= ROW_W'(511);
      last_col_r  <= CW'(COLS_RST - 1);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_TARGET:    target_r    <= cfg_data[PIX_W-1:0];
        CFG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        CFG_ROWS:      last_row_r  <= last_row_nxt;
        CFG_COLS:      last_col_r  <= last_col_nxt;
        default:       target_r    <= target_r;
      endcase
    end
  end

  bes_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .last_row (last_row_r),
    .last_col (last_col_r),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  bes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bes_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .target      (target_r),
    .threshold   (threshold_r),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule

[rtl/bes_checker.sv]
// ----------------------------------------------------------------------------
// bes_checker: port-level checks for the erosion stream
// Watches the top level's ports and reports violations.
// ----------------------------------------------------------------------------
module bes_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input bes_pkg::out_t out_data,
  input logic          out_stall,
  input logic          cfg_valid,
  input logic          cfg_ready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.run_last)
    else $error("frame end mark not on last result of its item");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind binary_erode_3x3_stream bes_checker u_bes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binary_erode_3x3_stream
// Streams frames in raster order through the input channel under random
// gaps and output stalls. Every accepted pixel runs through a local erosion
// predictor, and every result is matched against the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bes_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int LINE_DEPTH = 1024;
  localparam int IDLE_TAIL  = 16;
  localparam int N_DIR      = 23;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fs;
    logic             typed;
    out_t             want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_t                   in_data   = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_t                  out_data;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // erosion predictor state
  logic [PIX_W-1:0]  up_store  [0:LINE_DEPTH-1];
  logic [PIX_W-1:0]  mid_store [0:LINE_DEPTH-1];
  logic [PIX_W-1:0]  left_px   [0:1];
  logic [PIX_W-1:0]  win_u     [0:1];
  logic [PIX_W-1:0]  win_m     [0:1];
  int unsigned       row_ctr;
  int unsigned       col_ctr;
  logic [PIX_W-1:0]  cfg_tgt;
  logic [THR_W-1:0]  cfg_thr;
  logic [12:0]       cfg_rows;
  logic [10:0]       cfg_cols;

  out_t     step_px [0:2];
  int       step_n;
  out_t     pix_due [$];
  out_t     head;
  dir_row_t dir_tab [0:N_DIR-1];
  int       n_err     = 0;
  bit       in_quiet  = 1'b0;
  bit       out_quiet = 1'b0;

  binary_erode_3x3_stream #(
    .MAX_COLS (LINE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned frame_height();
    int unsigned h;
    h = cfg_rows;
    if (h < 3) h = 3;
    if (h > ROWS_MAX) h = ROWS_MAX;
    return h;
  endfunction

  function automatic int unsigned frame_width();
    int unsigned w;
    w = cfg_cols;
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic void clear_model();
    int k;
    for (k = 0; k < LINE_DEPTH; k++) begin
      up_store[k]  = '0;
      mid_store[k] = '0;
    end
    for (k = 0; k < 2; k++) begin
      left_px[k] = '0;
      win_u[k]   = '0;
      win_m[k]   = '0;
    end
    row_ctr  = 0;
    col_ctr  = 0;
    cfg_tgt  = 8'd255;
    cfg_thr  = 4'd4;
    cfg_rows = 13'd512;
    cfg_cols = 11'd512;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_TARGET:    cfg_tgt  = val[PIX_W-1:0];
      CFG_THRESHOLD: cfg_thr  = val[THR_W-1:0];
      CFG_ROWS:      cfg_rows = val[12:0];
      CFG_COLS:      cfg_cols = val[10:0];
      default: ;
    endcase
  endfunction

  function automatic void add_px(input logic [PIX_W-1:0] p, input int unsigned r,
                                 input int unsigned c, input logic done);
    step_px[step_n].pixel_out  = p;
    step_px[step_n].out_row    = r[ROW_W-1:0];
    step_px[step_n].out_col    = c[OCOL_W-1:0];
    step_px[step_n].run_last   = 1'b0;
    step_px[step_n].frame_done = done;
    step_n++;
  endfunction

  // Advance the predictor by one pixel; results land in step_px[0:step_n-1].
  function automatic void erode_step(input in_t d);
    int unsigned      hh, ww, rr, cc, zeros;
    logic [PIX_W-1:0] p, u, m, ctr, res;
    logic [PIX_W-1:0] win [0:8];
    int               k;
    hh = frame_height();
    ww = frame_width();
    p = d.pixel_in;
    step_n = 0;
    if (d.frame_start) begin
      row_ctr = 0;
      col_ctr = 0;
    end
    if (col_ctr >= ww) begin
      col_ctr = 0;
      row_ctr++;
    end
    if (row_ctr >= hh) row_ctr = 0;
    rr = row_ctr;
    cc = col_ctr;
    u = up_store[cc];
    m = mid_store[cc];
    win[0] = win_u[0];   win[1] = win_u[1];   win[2] = u;
    win[3] = win_m[0];   win[4] = win_m[1];   win[5] = m;
    win[6] = left_px[0]; win[7] = left_px[1]; win[8] = p;

    if (rr == 0) begin
      add_px(p, rr, cc, 1'b0);
    end else if (rr >= 2) begin
      if (cc >= 1) begin
        ctr = win_m[1];
        res = ctr;
        // left border column of the window centre is copied
        if (cc >= 2 && ctr == cfg_tgt) begin
          zeros = 0;
          for (k = 0; k < 9; k++) begin
            if (win[k] == '0) zeros++;
          end
          if (zeros > cfg_thr) res = '0;
        end
        add_px(res, rr - 1, cc - 1, 1'b0);
      end
      if (cc == ww - 1) add_px(m, rr - 1, cc, 1'b0);
      if (rr == hh - 1) add_px(p, rr, cc, cc == ww - 1);
    end
    if (step_n > 0) step_px[step_n - 1].run_last = 1'b1;

    win_u[0]   = win_u[1];
    win_u[1]   = u;
    win_m[0]   = win_m[1];
    win_m[1]   = m;
    left_px[0] = left_px[1];
    left_px[1] = p;
    up_store[cc]  = m;
    mid_store[cc] = p;
    if (cc + 1 >= ww) begin
      col_ctr = 0;
      row_ctr = (rr + 1 >= hh) ? 0 : rr + 1;
    end else begin
      col_ctr = cc + 1;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return cfg_tgt;
      4, 5, 6:    return 8'd0;
      7:          return 8'd255;
      default:    return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [12:0] pick_rows();
    logic [12:0] v;
    case ($urandom_range(0, 7))
      0:       v = 13'($urandom_range(0, 2));
      1:       v = 13'($urandom_range(10, 40));
      default: v = 13'($urandom_range(3, 9));
    endcase
    return v;
  endfunction

  function automatic logic [12:0] pick_cols();
    logic [12:0] v;
    case ($urandom_range(0, 7))
      0:       v = 13'($urandom_range(0, 2));
      1:       v = 13'($urandom_range(10, 16));
      default: v = 13'($urandom_range(3, 9));
    endcase
    // top bits lie above the column field
    v[12:11] = 2'($urandom_range(0, 3));
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_err++;
    if (n_err <= MAX_PRINTS)
      $display("%0t ns mismatch: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      if (ok) apply_reg(idx, val);
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic set_regs(input logic [12:0] tgt_d, thr_d, rows_d, cols_d);
    write_reg(CFG_TARGET, tgt_d);
    write_reg(CFG_THRESHOLD, thr_d);
    write_reg(CFG_ROWS, rows_d);
    write_reg(CFG_COLS, cols_d);
    cfg_valid <= 1'b0;
  endtask

  // Send one pixel; predict in the cycle that accepts it.
  task automatic push_pixel(input in_t d, input bit typed, input out_t typed_px);
    int gap;
    bit taken;
    int k;
    gap = in_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) begin
        erode_step(d);
        if (typed) begin
          pix_due.push_back(typed_px);
        end else begin
          for (k = 0; k < step_n; k++) pix_due.push_back(step_px[k]);
        end
      end
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pix_due.size() != 0) @(posedge clk);
    // row 1 pixels give no result but may still be in flight
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic run_phase(input int n_px, input logic [12:0] tgt_d, thr_d, rows_d, cols_d,
                           input bit restart);
    int unsigned w0;
    int          i;
    in_t         d;
    out_t        none;
    w0 = frame_width();
    none = '0;
    set_regs(tgt_d, thr_d, rows_d, cols_d);
    in_quiet  = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_px; i++) begin
      d.pixel_in = rand_pixel();
      // a wider frame must refill both line stores from row 0
      if (i == 0) d.frame_start = restart || (frame_width() > w0);
      else        d.frame_start = !restart && ($urandom_range(0, 49) == 0);
      push_pixel(d, 1'b0, none);
    end
    wait_idle();
  endtask

  // receiver: random stall before each result
  initial begin : stall_gen
    int hold;
    bit took;
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pix_due.size() == 0) begin
        report_mismatch("result with none due, pixel", int'(out_data.pixel_out), 0);
      end else begin
        head = pix_due.pop_front();
        if (out_data.pixel_out != head.pixel_out)
          report_mismatch("pixel_out", int'(out_data.pixel_out), int'(head.pixel_out));
        if (out_data.out_row != head.out_row)
          report_mismatch("out_row", int'(out_data.out_row), int'(head.out_row));
        if (out_data.out_col != head.out_col)
          report_mismatch("out_col", int'(out_data.out_col), int'(head.out_col));
        if (out_data.run_last != head.run_last)
          report_mismatch("run_last", int'(out_data.run_last), int'(head.run_last));
        if (out_data.frame_done != head.frame_done)
          report_mismatch("frame_done", int'(out_data.frame_done), int'(head.frame_done));
      end
    end
  end

  initial begin : stimulus
    in_t d;
    int  i;
    // columns: pixel, frame_start, typed, then pixel_out/row/col/run_last/frame_done
    // first frame, then a wrap into a second one without frame_start
    dir_tab[0]  = {8'd255, 1'b1, 1'b1, 8'd255, 12'd0, 10'd0, 1'b1, 1'b0};
    dir_tab[1]  = {8'd0,   1'b0, 1'b1, 8'd0,   12'd0, 10'd1, 1'b1, 1'b0};
    dir_tab[2]  = {8'd255, 1'b0, 1'b1, 8'd255, 12'd0, 10'd2, 1'b1, 1'b0};
    dir_tab[3]  = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[4]  = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[5]  = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[6]  = {8'd0,   1'b0, 1'b0, 32'd0};
    dir_tab[7]  = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[8]  = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[9]  = {8'd0,   1'b0, 1'b1, 8'd0,   12'd0, 10'd0, 1'b1, 1'b0};
    dir_tab[10] = {8'd255, 1'b0, 1'b1, 8'd255, 12'd0, 10'd1, 1'b1, 1'b0};
    dir_tab[11] = {8'd128, 1'b0, 1'b1, 8'd128, 12'd0, 10'd2, 1'b1, 1'b0};
    dir_tab[12] = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[13] = {8'd255, 1'b0, 1'b0, 32'd0};
    // restart in the middle of row 1, abandoning the frame
    dir_tab[14] = {8'd7,   1'b1, 1'b1, 8'd7,   12'd0, 10'd0, 1'b1, 1'b0};
    dir_tab[15] = {8'd255, 1'b0, 1'b1, 8'd255, 12'd0, 10'd1, 1'b1, 1'b0};
    dir_tab[16] = {8'd255, 1'b0, 1'b1, 8'd255, 12'd0, 10'd2, 1'b1, 1'b0};
    dir_tab[17] = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[18] = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[19] = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[20] = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[21] = {8'd255, 1'b0, 1'b0, 32'd0};
    dir_tab[22] = {8'd255, 1'b0, 1'b0, 32'd0};

    clear_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rows and columns below the minimum clamp to a 3x3 frame
    set_regs(13'd255, 13'd0, 13'd1, 13'd2);
    for (i = 0; i < N_DIR; i++) begin
      d.pixel_in    = dir_tab[i].pix;
      d.frame_start = dir_tab[i].fs;
      push_pixel(d, dir_tab[i].typed, dir_tab[i].want);
    end
    wait_idle();

    run_phase(40, 13'd255, 13'd4, 13'd5, 13'd6, 1'b0);
    for (i = 0; i < 3; i++)
      run_phase($urandom_range(15, 35), 13'($urandom_range(0, 8191)),
                13'($urandom_range(0, 8191)), pick_rows(), pick_cols(), 1'b0);
    // tallest frame setting; only its first rows are sent
    run_phase(30, 13'd255, 13'd9, 13'd4096, 13'd3, 1'b1);
    for (i = 0; i < 2; i++)
      run_phase($urandom_range(15, 35), 13'($urandom_range(0, 8191)),
                13'($urandom_range(0, 8191)), pick_rows(), pick_cols(), 1'b0);
    // over-range width clamps to the line store depth
    run_phase(30, 13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
              13'd6, 13'd2047, 1'b0);
    // full width; field value 1024 with the bits above it set; row 0 only
    run_phase(40, 13'd0, 13'd15, 13'd8191, 13'h1C00, 1'b1);
    for (i = 0; i < 3; i++)
      run_phase($urandom_range(15, 35), 13'($urandom_range(0, 8191)),
                13'($urandom_range(0, 8191)), pick_rows(), pick_cols(), 1'b0);

    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[binary_erode_3x3_stream.f]
rtl/bes_pkg.sv
rtl/bes_ram.sv
rtl/bes_front.sv
rtl/bes_queue.sv
rtl/bes_back.sv
rtl/binary_erode_3x3_stream.sv
rtl/bes_checker.sv
sim/testbench.sv
